/* design/lsps_pkg.sv */
// shared types and constants of the line sensor steering core
`default_nettype none

package lsps_pkg;

   localparam int SENSOR_W = 8;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int STEER_W  = 16;
   localparam int LERR_W   = 12;
   localparam int COUNT_W  = 4;
   localparam int WSUM_W   = 6;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_STRAIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CURVE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SHARP    = 3'd5;

   localparam logic [SENSOR_W-1:0] SENSOR_RESET = 8'hFF;
   localparam logic [COUNT_W-1:0]  CROSS_COUNT  = 4'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_DIV_DONE,
      ST_UPDATE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACCUM,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_ERR,
      MUL_INT,
      MUL_DIF
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        eval;
      logic        div_step;
      logic        div_finish;
      logic        update;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        add_en;
      logic        scale;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

   // probe weight, bit 0 is the rightmost probe
   function automatic logic signed [WSUM_W-1:0] probe_weight(input logic [2:0] idx);
      logic signed [WSUM_W-1:0] w;
      case (idx)
         3'd0:    w = 6'sd7;
         3'd1:    w = 6'sd5;
         3'd2:    w = 6'sd3;
         3'd3:    w = 6'sd1;
         3'd4:    w = -6'sd1;
         3'd5:    w = -6'sd3;
         3'd6:    w = -6'sd5;
         default: w = -6'sd7;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* design/lsps_channels.sv */
// handshake channel interfaces of the line sensor steering core
`default_nettype none

interface lsps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sensor_bits;
   logic       read_ok;
   modport source(output valid, output sensor_bits, output read_ok, input ready);
   modport sink(input valid, input sensor_bits, input read_ok, output ready);
endinterface

interface lsps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] steer;
   logic [9:0]         cruise_speed;
   logic               cross_line;
   logic [3:0]         black_count;
   logic signed [11:0] line_error;
   modport source(output valid, output steer, output cruise_speed, output cross_line,
                  output black_count, output line_error, input ready);
   modport sink(input valid, input steer, input cruise_speed, input cross_line,
                input black_count, input line_error, output ready);
endinterface

interface lsps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/lsps_ctrl.sv */
// sequencer of the line sensor steering core
`default_nettype none

module lsps_ctrl
   import lsps_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   input  status_type  status,
   output cmd_type     cmd
);

   localparam int NUM_W = FRAC_BITS + 5;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic             out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_ERR;
      req_ready    = 1'b0;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval   = 1'b1;
            div_cnt_in = '0;
            state_in   = status.need_div ? ST_DIVIDE : ST_UPDATE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = CNT_W'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == LAST_STEP) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INT;
            cmd.add_en  = 1'b1;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIF;
            cmd.add_en  = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.add_en = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_EVAL))
      else $error("accepted transaction not evaluated");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_cnt_ff <= LAST_STEP))
      else $error("divider ran past its last step");

   a_drop_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped without transaction");
`endif

endmodule

`default_nettype wire

/* design/lsps_datapath.sv */
// centroid error, divider, pid arithmetic and settings of the steering core
`default_nettype none

module lsps_datapath
   import lsps_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  wire [SENSOR_W-1:0]          sensor_bits,
   input  wire                         read_ok,
   input  wire                         csr_we,
   input  wire [CSR_IDX_W-1:0]         csr_index,
   input  wire [CSR_DAT_W-1:0]         csr_data,
   output logic signed [STEER_W-1:0]   steer,
   output logic [SPEED_W-1:0]          cruise_speed,
   output logic                        cross_line,
   output logic [COUNT_W-1:0]          black_count,
   output logic signed [LERR_W-1:0]    line_error
);

   localparam int ERR_W  = FRAC_BITS + 4;
   localparam int DIF_W  = FRAC_BITS + 5;
   localparam int INT_W  = FRAC_BITS + 6;
   localparam int MUL_W  = FRAC_BITS + 7;
   localparam int NUM_W  = FRAC_BITS + 5;
   localparam int PROD_W = MUL_W + GAIN_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SHIFT  = FRAC_BITS + 8;
   localparam int Q_W    = ACC_W - SHIFT;

   localparam logic signed [ERR_W-1:0] HALF_FIX   = ERR_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [ERR_W-1:0] LOST_FIX   = ERR_W'(6 << FRAC_BITS);
   localparam logic [ERR_W-1:0]        ZONE_A_FIX = ERR_W'(3 << (FRAC_BITS - 1));
   localparam logic [ERR_W-1:0]        ZONE_B_FIX = ERR_W'(7 << (FRAC_BITS - 1));
   localparam logic signed [INT_W:0]   ILIM_FIX   = (INT_W + 1)'(30 << FRAC_BITS);
   localparam logic [ACC_W-1:0]        ROUND_FIX  = ACC_W'((64'd1 << SHIFT) - 64'd1);
   localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
   localparam logic signed [Q_W-1:0]   Q_MIN      = -Q_W'(32768);

   // settings
   logic [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SPEED_W-1:0] speed_straight_ff, speed_curve_ff, speed_sharp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         speed_straight_ff <= '0;
         speed_curve_ff    <= '0;
         speed_sharp_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN_P:         gain_p_ff         <= csr_data;
            REG_GAIN_I:         gain_i_ff         <= csr_data;
            REG_GAIN_D:         gain_d_ff         <= csr_data;
            REG_SPEED_STRAIGHT: speed_straight_ff <= csr_data[SPEED_W-1:0];
            REG_SPEED_CURVE:    speed_curve_ff    <= csr_data[SPEED_W-1:0];
            REG_SPEED_SHARP:    speed_sharp_ff    <= csr_data[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // frame capture and weight sum
   logic [SENSOR_W-1:0]       frame_in;
   logic signed [WSUM_W-1:0]  wsum_in;
   logic [COUNT_W-1:0]        count_in;
   logic [SENSOR_W-1:0]       hold_ff;
   logic signed [WSUM_W-1:0]  wsum_ff;
   logic [COUNT_W-1:0]        count_ff;

   always_comb begin
      frame_in = read_ok ? sensor_bits : hold_ff;
      wsum_in  = '0;
      count_in = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (!frame_in[i]) begin
            wsum_in  = wsum_in + probe_weight(3'(i));
            count_in = count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= SENSOR_RESET;
      end else if (cmd.capture) begin
         hold_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wsum_ff  <= wsum_in;
         count_ff <= count_in;
      end
   end

   logic is_cross, is_lost;
   assign is_cross        = count_ff >= CROSS_COUNT;
   assign is_lost         = count_ff == '0;
   assign status.need_div = count_ff inside {[4'd1:4'd5]};

   // restoring divider, one quotient bit per step
   logic [WSUM_W-2:0] wmag;
   logic [NUM_W-1:0]  num_ff;
   logic [2:0]        rem_ff;
   logic [3:0]        trial;
   logic              qbit;

   assign wmag  = wsum_ff[WSUM_W-1] ? (WSUM_W-1)'(-wsum_ff) : wsum_ff[WSUM_W-2:0];
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign qbit  = trial >= count_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         num_ff <= NUM_W'(wmag) << FRAC_BITS;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], qbit};
         rem_ff <= qbit ? 3'(trial - count_ff) : trial[2:0];
      end
   end

   // error state
   logic signed [ERR_W-1:0] err_ff, last_valid_ff, prev_ff;
   logic signed [INT_W-1:0] integ_ff;
   logic signed [DIF_W-1:0] derr_ff;
   logic signed [ERR_W-1:0] quot;
   logic signed [INT_W:0]   isum;
   logic [ERR_W-1:0]        aerr;

   assign quot = wsum_ff[WSUM_W-1] ? -$signed(num_ff[ERR_W-1:0]) : $signed(num_ff[ERR_W-1:0]);
   assign isum = (INT_W + 1)'(integ_ff) + (INT_W + 1)'(err_ff);
   assign aerr = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff        <= '0;
         last_valid_ff <= '0;
         prev_ff       <= '0;
         integ_ff      <= '0;
      end else begin
         if (cmd.eval && !status.need_div) begin
            if (is_cross) begin
               err_ff <= '0;
            end else if (is_lost && last_valid_ff > HALF_FIX) begin
               err_ff <= LOST_FIX;
            end else if (is_lost && last_valid_ff < -HALF_FIX) begin
               err_ff <= -LOST_FIX;
            end else begin
               err_ff <= '0;
            end
         end else if (cmd.div_finish) begin
            err_ff        <= quot;
            last_valid_ff <= quot;
         end
         if (cmd.update) begin
            prev_ff <= err_ff;
            if (isum > ILIM_FIX) begin
               integ_ff <= INT_W'(ILIM_FIX);
            end else if (isum < -ILIM_FIX) begin
               integ_ff <= INT_W'(-ILIM_FIX);
            end else begin
               integ_ff <= INT_W'(isum);
            end
         end
      end
   end

   logic [SPEED_W-1:0] speed_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         derr_ff <= DIF_W'(err_ff) - DIF_W'(prev_ff);
         if (aerr <= ZONE_A_FIX) begin
            speed_ff <= speed_straight_ff;
         end else if (aerr <= ZONE_B_FIX) begin
            speed_ff <= speed_curve_ff;
         end else begin
            speed_ff <= speed_sharp_ff;
         end
      end
   end

   // shared multiplier and accumulator
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [GAIN_W:0]     mul_b;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR: begin
            mul_a = MUL_W'(err_ff);
            mul_b = $signed({1'b0, gain_p_ff});
         end
         MUL_INT: begin
            mul_a = MUL_W'(integ_ff);
            mul_b = $signed({1'b0, gain_i_ff});
         end
         MUL_DIF: begin
            mul_a = MUL_W'(derr_ff);
            mul_b = $signed({1'b0, gain_d_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         acc_ff <= '0;
      end else if (cmd.add_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // truncate toward zero, then saturate
   logic signed [ACC_W-1:0]   acc_adj;
   logic signed [Q_W-1:0]     q_val;
   logic signed [STEER_W-1:0] steer_ff;

   assign acc_adj = acc_ff + $signed(acc_ff[ACC_W-1] ? ROUND_FIX : '0);
   assign q_val   = Q_W'(acc_adj >>> SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         if (q_val > Q_MAX) begin
            steer_ff <= STEER_W'(Q_MAX);
         end else if (q_val < Q_MIN) begin
            steer_ff <= STEER_W'(Q_MIN);
         end else begin
            steer_ff <= STEER_W'(q_val);
         end
      end
   end

   // result register
   logic signed [ERR_W+LERR_W-1:0] err_wide;
   assign err_wide = (ERR_W + LERR_W)'(err_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         steer        <= steer_ff;
         cruise_speed <= speed_ff;
         cross_line   <= is_cross;
         black_count  <= count_ff;
         line_error   <= err_wide[LERR_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* design/line_sensor_pid_steering_core.sv */
// top level of the line sensor steering core
//
// req_chan takes one transaction per sensor frame: sensor_bits (bit 7 leftmost
// probe, 0 = black) and read_ok (0 reuses the held frame). rsp_chan returns one
// transaction per frame: steer, cruise_speed, cross_line, black_count, line_error.
// csr_chan writes the gain and speed registers by index, always ready; write
// only while no frame is in flight.
// a frame whose error needs no centroid division (cross line, line lost) skips the
// divider; otherwise the one-bit-per-cycle restoring divider runs first. The
// single shared multiplier then runs the three pid products in turn.
// one frame is in flight at a time; the core is ready for the next request in
// the cycle after it loads the result into the output register.
// the output register holds a result while rsp ready is low, and the core still
// takes and works on the next frame; it waits at the end only if the previous
// result has not been taken.
// reset clears the held frame to all white, and the error history, integral and
// gain and speed registers to zero; the other datapath registers are not reset.
`default_nettype none

module line_sensor_pid_steering_core
   import lsps_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire         clock,
   input  wire         reset,
   lsps_req_if.sink    req_chan,
   lsps_rsp_if.source  rsp_chan,
   lsps_csr_if.sink    csr_chan
);

   cmd_type    cmd;
   status_type status;

   assign csr_chan.ready = 1'b1;

   lsps_ctrl #(
      .FRAC_BITS(FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsps_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sensor_bits  (req_chan.sensor_bits),
      .read_ok      (req_chan.read_ok),
      .csr_we       (csr_chan.valid),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.data),
      .steer        (rsp_chan.steer),
      .cruise_speed (rsp_chan.cruise_speed),
      .cross_line   (rsp_chan.cross_line),
      .black_count  (rsp_chan.black_count),
      .line_error   (rsp_chan.line_error)
   );

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench of the line sensor steering core: frames checked against a built-in pid predictor
`timescale 1ns / 1ps

module tb
   import lsps_pkg::*;
();

   localparam int FRAC_BITS  = 8;
   localparam int ONE_FIX    = 1 << FRAC_BITS;
   localparam int HALF_FIX   = 1 << (FRAC_BITS - 1);
   localparam int LOST_FIX   = 6 * ONE_FIX;
   localparam int ILIMIT_FIX = 30 * ONE_FIX;
   localparam int ZONE_A_FIX = 3 * HALF_FIX;
   localparam int ZONE_B_FIX = 7 * HALF_FIX;
   localparam int SETTLE     = FRAC_BITS + 16;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic signed [15:0] steer;
      logic [9:0]         cruise_speed;
      logic               cross_line;
      logic [3:0]         black_count;
      logic signed [11:0] line_error;
   } steering_result_type;

   logic clock;
   logic reset;

   lsps_req_if req_chan();
   lsps_rsp_if rsp_chan();
   lsps_csr_if csr_chan();

   line_sensor_pid_steering_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // predictor state and register copies
   int cfg_gain_p, cfg_gain_i, cfg_gain_d;
   int cfg_speed_straight, cfg_speed_curve, cfg_speed_sharp;
   logic [7:0] held_frame;
   int last_good_err;
   int old_err;
   int integ_acc;

   steering_result_type expected_results[$];
   int mismatches;
   int idle_cycles;
   bit gaps_on;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic steering_result_type predict_steering(input logic [7:0] bits,
                                                            input logic fresh);
      int wsum, cnt, err, derr, aerr, speed;
      longint acc, q;
      steering_result_type r;
      if (fresh)
         held_frame = bits;
      wsum = 0;
      cnt = 0;
      for (int i = 0; i < 8; i++) begin
         if (!held_frame[i]) begin
            wsum += 7 - 2 * i;
            cnt++;
         end
      end
      if (cnt >= 6) begin
         err = 0;
      end else if (cnt == 0) begin
         if (last_good_err > HALF_FIX)
            err = LOST_FIX;
         else if (last_good_err < -HALF_FIX)
            err = -LOST_FIX;
         else
            err = 0;
      end else begin
         err = (wsum * ONE_FIX) / cnt;
         last_good_err = err;
      end
      derr = err - old_err;
      integ_acc += err;
      if (integ_acc > ILIMIT_FIX) integ_acc = ILIMIT_FIX;
      if (integ_acc < -ILIMIT_FIX) integ_acc = -ILIMIT_FIX;
      old_err = err;
      acc = longint'(err) * longint'(cfg_gain_p)
          + longint'(integ_acc) * longint'(cfg_gain_i)
          + longint'(derr) * longint'(cfg_gain_d);
      q = acc / (longint'(1) << (FRAC_BITS + 8));
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      aerr = (err < 0) ? -err : err;
      if (aerr <= ZONE_A_FIX)
         speed = cfg_speed_straight;
      else if (aerr <= ZONE_B_FIX)
         speed = cfg_speed_curve;
      else
         speed = cfg_speed_sharp;
      r.steer        = q[15:0];
      r.cruise_speed = speed[9:0];
      r.cross_line   = (cnt >= 6);
      r.black_count  = cnt[3:0];
      r.line_error   = err[11:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input steering_result_type want,
                                  input steering_result_type got);
      if (mismatches < 10) begin
         $display("%0t %s: expected steer=%0d speed=%0d cross=%0b count=%0d err=%0d",
                  $realtime, what, want.steer, want.cruise_speed, want.cross_line,
                  want.black_count, want.line_error);
         $display("   got steer=%0d speed=%0d cross=%0b count=%0d err=%0d",
                  got.steer, got.cruise_speed, got.cross_line, got.black_count,
                  got.line_error);
      end
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      steering_result_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.steer        = rsp_chan.steer;
         got.cruise_speed = rsp_chan.cruise_speed;
         got.cross_line   = rsp_chan.cross_line;
         got.black_count  = rsp_chan.black_count;
         got.line_error   = rsp_chan.line_error;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.steer !== want.steer || got.cruise_speed !== want.cruise_speed ||
                got.cross_line !== want.cross_line ||
                got.black_count !== want.black_count ||
                got.line_error !== want.line_error)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // result side stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready = 1'b0;
         stall_left = int'($urandom_range(1, 6)) - 1;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("** line_sensor_pid_steering_core: FAILED **");
         $finish;
      end
   end

   task automatic send_frame(input logic [7:0] bits, input logic fresh);
      if (gaps_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 6)) @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.sensor_bits = bits;
      req_chan.read_ok     = fresh;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_steering(bits, fresh));
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_GAIN_P:         cfg_gain_p = int'(data);
         REG_GAIN_I:         cfg_gain_i = int'(data);
         REG_GAIN_D:         cfg_gain_d = int'(data);
         REG_SPEED_STRAIGHT: cfg_speed_straight = int'(data[9:0]);
         REG_SPEED_CURVE:    cfg_speed_curve = int'(data[9:0]);
         REG_SPEED_SHARP:    cfg_speed_sharp = int'(data[9:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_regs(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                           input logic [15:0] s0, input logic [15:0] s1,
                           input logic [15:0] s2);
      wait_drained();
      write_reg(REG_GAIN_P, p);
      write_reg(REG_GAIN_I, i);
      write_reg(REG_GAIN_D, d);
      write_reg(REG_SPEED_STRAIGHT, s0);
      write_reg(REG_SPEED_CURVE, s1);
      write_reg(REG_SPEED_SHARP, s2);
   endtask

   task automatic random_regs();
      set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endtask

   // mostly line-like frames, some cross lines, lost lines and noise
   task automatic pick_frame(output logic [7:0] bits, output logic fresh);
      logic [7:0] mask;
      int kind, width, pos;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         width = $urandom_range(1, 3);
         pos = $urandom_range(0, 8 - width);
         mask = ((8'd1 << width) - 8'd1) << pos;
         bits = ~mask;
      end else if (kind < 52) begin
         bits = ~((8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7)));
      end else if (kind < 64) begin
         bits = 8'hFF;
      end else if (kind < 74) begin
         mask = 8'hFF;
         mask[$urandom_range(0, 7)] = 1'b0;
         mask[$urandom_range(0, 7)] = 1'b0;
         bits = ~mask;
      end else begin
         bits = 8'($urandom_range(0, 255));
      end
      fresh = ($urandom_range(0, 99) >= 15);
      if (!fresh)
         bits = 8'($urandom_range(0, 255));
   endtask

   task automatic send_random(input int count);
      logic [7:0] bits;
      logic fresh;
      repeat (count) begin
         pick_frame(bits, fresh);
         send_frame(bits, fresh);
      end
   endtask

   task automatic test_reset_registers();
      send_frame(8'hFF, 1'b1);
      send_frame(8'hE7, 1'b1);
      send_random(20);
   endtask

   task automatic test_directed_frames();
      set_regs(16'h0180, 16'h0040, 16'h0200, 16'd600, 16'd400, 16'd200);
      send_frame(8'hFF, 1'b1);
      send_frame(8'h7F, 1'b1);  // leftmost probe
      send_frame(8'hFF, 1'b1);  // lost, last error negative
      send_frame(8'hFE, 1'b1);  // rightmost probe
      send_frame(8'hFF, 1'b1);  // lost, last error positive
      send_frame(8'h00, 1'b0);  // stale frame reused
      send_frame(8'hE7, 1'b1);
      send_frame(8'hFF, 1'b1);  // lost near center
      send_frame(8'hA6, 1'b1);  // plus one half
      send_frame(8'hFF, 1'b1);
      send_frame(8'h65, 1'b1);  // minus one half
      send_frame(8'hFF, 1'b1);
      send_frame(8'hAC, 1'b1);  // straight zone edge
      send_frame(8'hE8, 1'b1);  // curve zone edge
      send_frame(8'h03, 1'b1);  // six black, cross line
      send_frame(8'h07, 1'b1);  // five black
      send_frame(8'h00, 1'b1);  // all black
      send_frame(8'hFF, 1'b0);
      send_frame(8'hF8, 1'b1);
      send_frame(8'hBF, 1'b1);
      send_frame(8'hFB, 1'b1);
      send_frame(8'h5A, 1'b1);
      send_frame(8'hF4, 1'b1);  // division truncates, positive
      send_frame(8'h2F, 1'b1);  // division truncates, negative
   endtask

   task automatic test_gain_extremes();
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (6) send_frame(8'hFE, 1'b1);  // integral up to its clamp
      repeat (10) send_frame(8'h7F, 1'b1);
      send_random(30);
      wait_drained();
      write_reg(REG_SPARE_6, 16'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_7, 16'($urandom_range(0, 65535)));
      send_random(20);
      set_regs(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h03FF, 16'hFC00);
      send_random(30);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         random_regs();
         send_random(280);
      end
   endtask

   task automatic test_drain_pause();
      random_regs();
      repeat (4) begin
         send_random(25);
         wait_drained();
      end
   endtask

   task automatic test_steady_flow();
      wait_drained();
      gaps_on = 1'b0;
      random_regs();
      send_random(120);
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.sensor_bits = '0;
      req_chan.read_ok = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      cfg_gain_p = 0;
      cfg_gain_i = 0;
      cfg_gain_d = 0;
      cfg_speed_straight = 0;
      cfg_speed_curve = 0;
      cfg_speed_sharp = 0;
      held_frame = SENSOR_RESET;
      last_good_err = 0;
      old_err = 0;
      integ_acc = 0;
      mismatches = 0;
      idle_cycles = 0;
      stall_left = 0;
      gaps_on = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_registers();
      test_directed_frames();
      test_gain_extremes();
      test_random_settings();
      test_drain_pause();
      test_steady_flow();

      wait_drained();
      if (mismatches == 0) begin
         $display("** line_sensor_pid_steering_core: PASSED **");
      end else begin
         $display("** line_sensor_pid_steering_core: FAILED **");
      end
      $finish;
   end

endmodule
